>>> rtl/pcr_pkg.sv
// Package for the pair-to-residue correlation block.
// Item types, commands, state encoding and sizes; no dependencies.
package pcr_pkg;

  localparam int PAIRS_MAX = 256;
  localparam int PIDX_W    = $clog2(PAIRS_MAX);
  localparam int PCNT_W    = PIDX_W + 1;
  localparam int CADDR_W   = 2 * PIDX_W;
  localparam int RES_W     = 10;
  localparam int NRES_W    = 11;
  localparam int NPAIR_W   = 9;
  localparam int VAL_W     = 16;
  localparam int ABS_W     = VAL_W + 1;
  localparam int SUM_W     = 30;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAIRS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RES   = 1'd1;

  localparam logic [NPAIR_W-1:0] NUM_PAIRS_RST = 9'd1;
  localparam logic [NRES_W-1:0]  NUM_RES_RST   = 11'd1024;

  typedef enum logic [1:0] {
    CMD_PAIR  = 2'd0,
    CMD_CORR  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [7:0]              pair_slot;
    logic [RES_W-1:0]        residue_a;
    logic [RES_W-1:0]        residue_b;
    logic [7:0]              row;
    logic [7:0]              col;
    logic signed [VAL_W-1:0] value;
  } pcr_in_t;

  typedef struct packed {
    logic [RES_W-1:0] query_a;
    logic [RES_W-1:0] query_b;
    logic [SUM_W-1:0] sum_abs;
    logic             out_of_range;
  } pcr_out_t;

  typedef struct packed {
    logic [RES_W-1:0] res_b;
    logic [RES_W-1:0] res_a;
  } pcr_pair_t;

  typedef struct packed {
    logic             clr;
    logic             acc_en;
    logic [RES_W-1:0] qa;
    logic [RES_W-1:0] qb;
  } pcr_ctl_t;

  typedef struct packed {
    logic pair_we;
    logic corr_we;
  } pcr_wr_t;

endpackage

>>> rtl/pair_corr_to_residue_corr.sv
// Query: walks the n(n-1)/2 pairs kl < ij for n = min(num_pairs, 256), then drains and outputs;
// it goes straight to output when n < 2 or a residue is out of range; loads never make it busy.
// One correlation read per cycle from the matrix memory port sets the walk rate.
// The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset clears control and config; tables stay undefined.
module pair_corr_to_residue_corr (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  pcr_pkg::pcr_in_t              in_item,
  output logic                          out_valid,
  output pcr_pkg::pcr_out_t             out_item,
  input  logic                          cfg_we,
  input  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pcr_pkg::CFG_W-1:0]     cfg_data
);
  import pcr_pkg::*;

  pcr_wr_t                 wr;
  pcr_ctl_t                ctl;
  logic                    rd_en, bad;
  logic [PIDX_W-1:0]       ij, kl;
  pcr_pair_t               p_hi, p_lo, p_new;
  logic signed [VAL_W-1:0] corr;
  logic [SUM_W-1:0]        sum;

  assign p_new.res_a = in_item.residue_a;
  assign p_new.res_b = in_item.residue_b;

  pcr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .rd_en     (rd_en),
    .ij        (ij),
    .kl        (kl),
    .ctl       (ctl),
    .out_valid (out_valid),
    .bad       (bad)
  );

  pcr_pair_mem u_pair_mem (
    .clk    (clk),
    .we     (wr.pair_we),
    .waddr  (PIDX_W'(in_item.pair_slot)),
    .wdata  (p_new),
    .re     (rd_en),
    .raddr0 (ij),
    .raddr1 (kl),
    .rdata0 (p_hi),
    .rdata1 (p_lo)
  );

  pcr_correl_mem u_correl_mem (
    .clk   (clk),
    .we    (wr.corr_we),
    .waddr ({PIDX_W'(in_item.row), PIDX_W'(in_item.col)}),
    .wdata (in_item.value),
    .re    (rd_en),
    .raddr ({ij, kl}),
    .rdata (corr)
  );

  pcr_accum u_accum (
    .clk  (clk),
    .ctl  (ctl),
    .p_hi (p_hi),
    .p_lo (p_lo),
    .corr (corr),
    .sum  (sum)
  );

  assign out_item.query_a      = ctl.qa;
  assign out_item.query_b      = ctl.qb;
  assign out_item.sum_abs      = bad ? '0 : sum;
  assign out_item.out_of_range = bad;

endmodule

>>> rtl/pcr_pair_mem.sv
// Pair table: one write port, two registered read ports.
// Depends on pcr_pkg.
module pcr_pair_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [pcr_pkg::PIDX_W-1:0] waddr,
  input  pcr_pkg::pcr_pair_t        wdata,
  input  logic                      re,
  input  logic [pcr_pkg::PIDX_W-1:0] raddr0,
  input  logic [pcr_pkg::PIDX_W-1:0] raddr1,
  output pcr_pkg::pcr_pair_t        rdata0,
  output pcr_pkg::pcr_pair_t        rdata1
);
  import pcr_pkg::*;

  pcr_pair_t mem [PAIRS_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

>>> rtl/pcr_correl_mem.sv
// Correlation matrix store, row-major, one write and one registered read port.
// Depends on pcr_pkg.
module pcr_correl_mem (
  input  logic                              clk,
  input  logic                              we,
  input  logic [pcr_pkg::CADDR_W-1:0]        waddr,
  input  logic signed [pcr_pkg::VAL_W-1:0]   wdata,
  input  logic                              re,
  input  logic [pcr_pkg::CADDR_W-1:0]        raddr,
  output logic signed [pcr_pkg::VAL_W-1:0]   rdata
);
  import pcr_pkg::*;

  logic signed [VAL_W-1:0] mem [PAIRS_MAX*PAIRS_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pcr_seq.sv
// Sequencer: command decode, config registers, walk over kl < ij.
// Depends on pcr_pkg.
module pcr_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  pcr_pkg::pcr_in_t            in_item,
  output logic                        busy,
  input  logic                        cfg_we,
  input  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pcr_pkg::CFG_W-1:0]   cfg_data,
  output pcr_pkg::pcr_wr_t            wr,
  output logic                        rd_en,
  output logic [pcr_pkg::PIDX_W-1:0]  ij,
  output logic [pcr_pkg::PIDX_W-1:0]  kl,
  output pcr_pkg::pcr_ctl_t           ctl,
  output logic                        out_valid,
  output logic                        bad
);
  import pcr_pkg::*;

  state_t               state_r, state_nxt;
  logic [PIDX_W-1:0]    ij_r, ij_nxt, kl_r, kl_nxt;
  logic [PCNT_W-1:0]    n_r, n_nxt, n_calc;
  logic [RES_W-1:0]     qa_r, qa_nxt, qb_r, qb_nxt;
  logic                 bad_r, bad_nxt, bad_calc;
  logic                 iss_r;
  logic [NPAIR_W-1:0]   num_pairs_r;
  logic [NRES_W-1:0]    num_res_r;
  logic                 acc, q_go, row_end, last;

  assign acc = start && (state_r == ST_IDLE);

  always_comb begin
    q_go    = 1'b0;
    wr      = '0;
    unique case (in_item.cmd)
      CMD_PAIR:  wr.pair_we = acc && (32'(in_item.pair_slot) < PAIRS_MAX);
      CMD_CORR:  wr.corr_we = acc && (32'(in_item.row) < PAIRS_MAX)
                              && (32'(in_item.col) < PAIRS_MAX);
      CMD_QUERY: q_go = acc;
      default:   q_go = 1'b0;
    endcase
  end

  assign n_calc = (32'(num_pairs_r) > PAIRS_MAX) ? PCNT_W'(PAIRS_MAX)
                                                 : PCNT_W'(num_pairs_r);
  assign bad_calc = ({1'b0, in_item.residue_a} >= num_res_r)
                 || ({1'b0, in_item.residue_b} >= num_res_r);
  assign row_end = (kl_r == ij_r - PIDX_W'(1));
  assign last    = row_end && ((PCNT_W'(ij_r) + PCNT_W'(1)) == n_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_go) begin
          state_nxt = (bad_calc || n_calc <= PCNT_W'(1)) ? ST_OUT : ST_WALK;
        end
      end
      ST_WALK:  if (last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ij_nxt  = ij_r;
    kl_nxt  = kl_r;
    n_nxt   = n_r;
    qa_nxt  = qa_r;
    qb_nxt  = qb_r;
    bad_nxt = bad_r;
    if (q_go) begin
      ij_nxt  = PIDX_W'(1);
      kl_nxt  = '0;
      n_nxt   = n_calc;
      qa_nxt  = in_item.residue_a;
      qb_nxt  = in_item.residue_b;
      bad_nxt = bad_calc;
    end else if (state_r == ST_WALK) begin
      if (row_end) begin
        ij_nxt = ij_r + PIDX_W'(1);
        kl_nxt = '0;
      end else begin
        kl_nxt = kl_r + PIDX_W'(1);
      end
    end
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    rd_en     = (state_r == ST_WALK);
    out_valid = (state_r == ST_OUT);
  end

  assign ij         = ij_r;
  assign kl         = kl_r;
  assign bad        = bad_r;
  assign ctl.clr    = q_go;
  assign ctl.acc_en = iss_r;
  assign ctl.qa     = qa_r;
  assign ctl.qb     = qb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= 1'b0;
      num_pairs_r <= NUM_PAIRS_RST;
      num_res_r   <= NUM_RES_RST;
    end else begin
      state_r <= state_nxt;
      iss_r   <= rd_en;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_NUM_PAIRS: num_pairs_r <= cfg_data[NPAIR_W-1:0];
          CFG_NUM_RES:   num_res_r   <= cfg_data[NRES_W-1:0];
          default:       num_res_r   <= num_res_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ij_r  <= ij_nxt;
    kl_r  <= kl_nxt;
    n_r   <= n_nxt;
    qa_r  <= qa_nxt;
    qb_r  <= qb_nxt;
    bad_r <= bad_nxt;
  end

endmodule

>>> rtl/pcr_accum.sv
// Match test, absolute value and saturating accumulator.
// Depends on pcr_pkg.
module pcr_accum (
  input  logic                            clk,
  input  pcr_pkg::pcr_ctl_t               ctl,
  input  pcr_pkg::pcr_pair_t              p_hi,
  input  pcr_pkg::pcr_pair_t              p_lo,
  input  logic signed [pcr_pkg::VAL_W-1:0] corr,
  output logic [pcr_pkg::SUM_W-1:0]       sum
);
  import pcr_pkg::*;

  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic             hi_a, hi_b, lo_a, lo_b, hit;
  logic [ABS_W-1:0] mag;
  logic [SUM_W:0]   add;

  assign hi_a = (p_hi.res_a == ctl.qa) || (p_hi.res_b == ctl.qa);
  assign hi_b = (p_hi.res_a == ctl.qb) || (p_hi.res_b == ctl.qb);
  assign lo_a = (p_lo.res_a == ctl.qa) || (p_lo.res_b == ctl.qa);
  assign lo_b = (p_lo.res_a == ctl.qb) || (p_lo.res_b == ctl.qb);
  assign hit  = (hi_a && lo_b) || (hi_b && lo_a);

  assign mag = corr[VAL_W-1] ? (ABS_W'(0) - {corr[VAL_W-1], corr})
                             : {1'b0, corr};
  assign add = {1'b0, acc_r} + (SUM_W+1)'(mag);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en && hit) begin
      acc_nxt = add[SUM_W] ? {SUM_W{1'b1}} : add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign sum = acc_r;

endmodule

>>> tb/sv/pair_corr_to_residue_corr_tb.sv
// Testbench for pair_corr_to_residue_corr: loads pair and correlation items,
// queries residue pairs and checks every answer against an in-bench predictor.
// Depends on pcr_pkg and the pair_corr_to_residue_corr RTL.
module pair_corr_to_residue_corr_tb;
  import pcr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint     SUM_CAP    = (64'd1 << SUM_W) - 1;
  localparam int         IDLE_LIMIT = 150000;

  logic                 clk;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic                 busy;
  pcr_in_t              in_item  = '0;
  logic                 out_valid;
  pcr_out_t             out_item;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state, updated as items are accepted
  pcr_pair_t   pair_mem [PAIRS_MAX];
  logic [15:0] corr_mem [PAIRS_MAX*PAIRS_MAX];
  int          pairs_cfg = int'(NUM_PAIRS_RST);
  int          res_cfg   = int'(NUM_RES_RST);
  pcr_out_t    answers_due [$];

  // stimulus planning state, tracks what has been written so far
  pcr_pair_t plan_pair    [PAIRS_MAX];
  bit        plan_pair_ok [PAIRS_MAX];
  bit        plan_corr_ok [PAIRS_MAX*PAIRS_MAX];
  int        plan_np   = int'(NUM_PAIRS_RST);
  int        plan_nres = int'(NUM_RES_RST);
  int        fill_max  = 16;
  pcr_in_t   cmd_queue [$];

  int       errors      = 0;
  int       idle_cycles = 0;
  int       gap_left    = 0;
  int       burst_left  = 1;
  pcr_out_t want;

  pair_corr_to_residue_corr dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int walked(int np);
    return (np > PAIRS_MAX) ? PAIRS_MAX : np;
  endfunction

  function automatic bit touches(pcr_pair_t p, logic [RES_W-1:0] r);
    return (p.res_a == r) || (p.res_b == r);
  endfunction

  function automatic logic [SUM_W-1:0] residue_sum(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
    longint total;
    int     n;
    int     v;
    bit     ha, hb;
    total = 0;
    n = walked(pairs_cfg);
    for (int ij = 1; ij < n; ij++) begin
      ha = touches(pair_mem[ij], a);
      hb = touches(pair_mem[ij], b);
      if (ha || hb) begin
        for (int kl = 0; kl < ij; kl++) begin
          if ((ha && touches(pair_mem[kl], b)) || (hb && touches(pair_mem[kl], a))) begin
            v = int'($signed(corr_mem[ij*PAIRS_MAX + kl]));
            total += longint'((v < 0) ? -v : v);
          end
        end
      end
    end
    return (total > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : total[SUM_W-1:0];
  endfunction

  task automatic record_item(pcr_in_t it);
    pcr_out_t ans;
    case (it.cmd)
      CMD_PAIR: begin
        pair_mem[it.pair_slot].res_a = it.residue_a;
        pair_mem[it.pair_slot].res_b = it.residue_b;
      end
      CMD_CORR: corr_mem[it.row*PAIRS_MAX + it.col] = it.value;
      CMD_QUERY: begin
        ans.query_a = it.residue_a;
        ans.query_b = it.residue_b;
        ans.out_of_range = (it.residue_a >= res_cfg) || (it.residue_b >= res_cfg);
        ans.sum_abs = ans.out_of_range ? '0 : residue_sum(it.residue_a, it.residue_b);
        answers_due.push_back(ans);
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) record_item(in_item);
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_queue.size() != 0) begin
          in_item <= cmd_queue.pop_front();
          start   <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result a=%0d b=%0d",
                                out_item.query_a, out_item.query_b));
      end else begin
        want = answers_due.pop_front();
        if (out_item.query_a !== want.query_a)
          flag_mismatch($sformatf("query_a got %0d want %0d", out_item.query_a, want.query_a));
        if (out_item.query_b !== want.query_b)
          flag_mismatch($sformatf("query_b got %0d want %0d", out_item.query_b, want.query_b));
        if (out_item.sum_abs !== want.sum_abs)
          flag_mismatch($sformatf("sum_abs got %0d want %0d (a=%0d b=%0d)",
                                  out_item.sum_abs, want.sum_abs, want.query_a, want.query_b));
        if (out_item.out_of_range !== want.out_of_range)
          flag_mismatch($sformatf("out_of_range got %0b want %0b (a=%0d b=%0d)",
                                  out_item.out_of_range, want.out_of_range,
                                  want.query_a, want.query_b));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pcr_in_t noise_item(logic [1:0] c);
    logic [63:0] raw;
    pcr_in_t     it;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(pcr_in_t)-1:0];
    it.cmd = c;
    return it;
  endfunction

  function automatic logic [RES_W-1:0] rand_res();
    return RES_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, fill_max - 1));
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return VAL_W'($urandom());
    endcase
  endfunction

  function automatic logic [RES_W-1:0] pick_res();
    int n, s, r;
    n = walked(plan_np);
    r = $urandom_range(0, 9);
    if (r < 7 && n > 0) begin
      s = $urandom_range(0, n - 1);
      if (plan_pair_ok[s]) return $urandom_range(0, 1) ? plan_pair[s].res_a : plan_pair[s].res_b;
    end
    if (r == 9) return RES_W'($urandom_range(0, 1023));
    return RES_W'($urandom_range(0, fill_max - 1));
  endfunction

  task automatic push_item(pcr_in_t it);
    case (it.cmd)
      CMD_PAIR: begin
        plan_pair[it.pair_slot].res_a = it.residue_a;
        plan_pair[it.pair_slot].res_b = it.residue_b;
        plan_pair_ok[it.pair_slot] = 1'b1;
      end
      CMD_CORR: plan_corr_ok[it.row*PAIRS_MAX + it.col] = 1'b1;
      default: ;
    endcase
    cmd_queue.push_back(it);
  endtask

  task automatic load_pair(int s, logic [RES_W-1:0] a, logic [RES_W-1:0] b);
    pcr_in_t it;
    it = noise_item(CMD_PAIR);
    it.pair_slot = 8'(s);
    it.residue_a = a;
    it.residue_b = b;
    push_item(it);
  endtask

  task automatic load_corr(int r, int c, logic [VAL_W-1:0] v);
    pcr_in_t it;
    it = noise_item(CMD_CORR);
    it.row   = 8'(r);
    it.col   = 8'(c);
    it.value = v;
    push_item(it);
  endtask

  // query; first loads whatever pair or matching matrix entry it would use unwritten
  task automatic ask(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
    pcr_in_t it;
    int      n;
    bit      ha, hb;
    n = walked(plan_np);
    if (a < plan_nres && b < plan_nres) begin
      for (int s = 0; s < n; s++)
        if (!plan_pair_ok[s]) load_pair(s, rand_res(), rand_res());
      for (int ij = 1; ij < n; ij++) begin
        ha = touches(plan_pair[ij], a);
        hb = touches(plan_pair[ij], b);
        if (ha || hb) begin
          for (int kl = 0; kl < ij; kl++)
            if (((ha && touches(plan_pair[kl], b)) || (hb && touches(plan_pair[kl], a)))
                && !plan_corr_ok[ij*PAIRS_MAX + kl])
              load_corr(ij, kl, rand_val());
        end
      end
    end
    it = noise_item(CMD_QUERY);
    it.residue_a = a;
    it.residue_b = b;
    push_item(it);
  endtask

  task automatic rand_item();
    int               r, n, s;
    logic [RES_W-1:0] a;
    r = $urandom_range(0, 99);
    n = walked(plan_np);
    if (r < 40) begin
      a = pick_res();
      ask(a, ($urandom_range(0, 9) == 0) ? a : pick_res());
    end else if (r < 65) begin
      s = ($urandom_range(0, 4) != 0 && n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
      load_pair(s, rand_res(), rand_res());
    end else if (r < 92) begin
      if ($urandom_range(0, 4) != 0 && n > 0)
        load_corr($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_val());
      else
        load_corr($urandom_range(0, 255), $urandom_range(0, 255), rand_val());
    end else begin
      push_item(noise_item(CMD_UNUSED));
    end
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || start || answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    wait_idle();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_PAIRS) begin
      pairs_cfg = int'(data[NPAIR_W-1:0]);
      plan_np   = int'(data[NPAIR_W-1:0]);
    end else begin
      res_cfg   = int'(data);
      plan_nres = int'(data);
    end
    @(negedge clk);
  endtask

  int np_list [6] = '{2, 5, 9, 16, 1, 12};
  int nr_list [6] = '{1024, 8, 2047, 600, 16, 2};

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset config, one pair walked
    push_item(noise_item(CMD_UNUSED));
    load_pair(0, 10'd0, 10'd1023);
    ask(10'd0, 10'd1023);

    set_cfg(CFG_NUM_PAIRS, 11'd3);
    load_pair(0, 10'd5, 10'd6);
    load_pair(1, 10'd6, 10'd7);
    load_pair(2, 10'd5, 10'd5);
    load_pair(255, 10'd1023, 10'd0);
    load_corr(1, 0, 16'h8000);
    load_corr(2, 0, 16'h7FFF);
    load_corr(2, 1, 16'hFFFF);
    load_corr(255, 255, 16'h7FFF);
    load_corr(0, 255, 16'h8000);
    ask(10'd5, 10'd6);
    ask(10'd6, 10'd5);
    ask(10'd5, 10'd5);
    ask(10'd7, 10'd7);
    ask(10'd1023, 10'd1023);

    set_cfg(CFG_NUM_RES, 11'd2);
    ask(10'd0, 10'd1);
    ask(10'd2, 10'd0);
    ask(10'd1, 10'd1023);

    set_cfg(CFG_NUM_PAIRS, 11'd0);
    set_cfg(CFG_NUM_RES, 11'd1024);
    ask(10'd5, 10'd6);

    // random phases with small pair counts
    fill_max = 12;
    for (int p = 0; p < 6; p++) begin
      set_cfg(CFG_NUM_PAIRS, CFG_W'(np_list[p]));
      set_cfg(CFG_NUM_RES, CFG_W'(nr_list[p]));
      repeat (15) rand_item();
    end

    // full-size walks, few queries
    fill_max = 1024;
    set_cfg(CFG_NUM_PAIRS, 11'd256);
    set_cfg(CFG_NUM_RES, 11'd1024);
    ask(pick_res(), pick_res());
    ask(pick_res(), pick_res());
    repeat (4) rand_item();

    // upper bits of the data are dropped: num_pairs 511, clamped to the table size
    set_cfg(CFG_NUM_PAIRS, 11'h7FF);
    set_cfg(CFG_NUM_RES, 11'd1000);
    ask(pick_res(), pick_res());
    ask(pick_res(), 10'd1000);
    repeat (3) rand_item();

    wait_idle();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/pcr_pkg.sv
rtl/pcr_pair_mem.sv
rtl/pcr_correl_mem.sv
rtl/pcr_seq.sv
rtl/pcr_accum.sv
rtl/pair_corr_to_residue_corr.sv
tb/sv/pair_corr_to_residue_corr_tb.sv
